// ===== src/ssd_pkg.sv =====
// Shared types and constants for the descending Shell sort block.
// No dependencies; compiled before every other file of the block.
`timescale 1ns / 1ps

package ssd_pkg;

	// divide by three for small values: (x * 43) >> 7 is exact below 128
	localparam int DIV3_MUL   = 43;
	localparam int DIV3_SHIFT = 7;

	// result hand-over from the sequencer to the output register
	typedef struct packed {
		logic load;
		logic final_flag;
		logic dropped;
	} ssd_emit_t;

endpackage

// ===== src/ssd_stream_if.sv =====
// Valid/ready channels of the descending Shell sort block: input items and results.
// No dependencies.
`timescale 1ns / 1ps

interface ssd_in_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] value;
	logic                         is_last;

	modport source (output valid, value, is_last, input ready);
	modport sink   (input valid, value, is_last, output ready);
endinterface

interface ssd_out_if #(parameter int DATA_WIDTH = 32);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] sorted_value;
	logic                         final_flag;
	logic                         dropped;

	modport source (output valid, sorted_value, final_flag, dropped, input ready);
	modport sink   (input valid, sorted_value, final_flag, dropped, output ready);
endinterface

// ===== src/ssd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module ssd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ===== src/ssd_seq.sv =====
// Sequencer of the descending Shell sort: loads items into the element RAM,
// runs the gap-insertion passes in place and reads the results back out.
// Depends on ssd_pkg, ssd_stream_if and ssd_ram.
`timescale 1ns / 1ps

module ssd_seq #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	ssd_in_if.sink                        items,
	input  logic                          out_free,
	output ssd_pkg::ssd_emit_t            emit,
	output logic signed [DATA_WIDTH-1:0]  emit_value
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);

	typedef enum logic [2:0] {
		S_LOAD, S_GAP, S_ROW, S_CUR, S_CMP, S_PUT, S_ERD, S_EWAIT
	} state_t;

	state_t                        state_q;
	logic [CW-1:0]                 count_q;
	logic [CW-1:0]                 gap_q;
	logic [CW-1:0]                 i_q;
	logic [CW-1:0]                 pos_q;
	logic [CW-1:0]                 k_q;
	logic signed [DATA_WIDTH-1:0]  cur_q;
	logic                          ovf_q;

	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr;
	logic [DATA_WIDTH-1:0]         ram_wdata;
	logic [AW-1:0]                 ram_raddr;
	logic [DATA_WIDTH-1:0]         ram_rdata;

	logic                          accept;
	logic                          has_room;
	logic [CW-1:0]                 n_new;
	logic [CW:0]                   row_idx;
	logic                          row_ok;
	logic [CW-1:0]                 pos_dn;
	logic [CW-1:0]                 pos_dn2;
	logic                          shift;
	logic                          more;
	logic [CW+7:0]                 gap_prod;
	logic [CW-1:0]                 gap_nxt;
	logic                          is_final;

	ssd_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (MAX_ITEMS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// handshake and load bookkeeping
	assign items.ready = (state_q == S_LOAD);
	assign accept      = items.valid && items.ready;
	assign has_room    = (count_q != CW'(MAX_ITEMS));
	assign n_new       = has_room ? (count_q + CW'(1)) : count_q;

	// next gap: gap / 3 + 1
	assign gap_prod = (CW+8)'(gap_q) * (CW+8)'(ssd_pkg::DIV3_MUL);
	assign gap_nxt  = CW'(gap_prod >> ssd_pkg::DIV3_SHIFT) + CW'(1);

	// insertion step arithmetic
	assign row_idx = {1'b0, i_q} + {1'b0, gap_q};
	assign row_ok  = (row_idx < {1'b0, count_q});
	assign pos_dn  = pos_q - gap_q;
	assign pos_dn2 = pos_dn - gap_q;
	assign shift   = ($signed(ram_rdata) < cur_q);
	assign more    = (pos_dn >= gap_q);

	assign is_final = (k_q == (count_q - CW'(1)));

	// RAM access per state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = items.value;
		ram_raddr = k_q[AW-1:0];
		case (state_q)
			S_LOAD: begin
				ram_we = accept && has_room;
			end
			S_ROW: begin
				ram_raddr = row_idx[AW-1:0];
			end
			S_CUR: begin
				ram_raddr = pos_dn[AW-1:0];
			end
			S_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = shift ? ram_rdata : cur_q;
				ram_raddr = pos_dn2[AW-1:0];
			end
			S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = cur_q;
			end
			default: begin
			end
		endcase
	end

	// result hand-over
	assign emit.load       = (state_q == S_EWAIT);
	assign emit.final_flag = is_final;
	assign emit.dropped    = ovf_q;
	assign emit_value      = $signed(ram_rdata);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			gap_q   <= '0;
			i_q     <= '0;
			pos_q   <= '0;
			k_q     <= '0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (has_room) begin
							count_q <= count_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (items.is_last) begin
							gap_q   <= n_new;
							state_q <= S_GAP;
						end
					end
				end
				S_GAP: begin
					if (gap_q > CW'(1)) begin
						gap_q   <= gap_nxt;
						i_q     <= '0;
						state_q <= S_ROW;
					end else begin
						k_q     <= '0;
						state_q <= S_ERD;
					end
				end
				S_ROW: begin
					if (row_ok) begin
						pos_q   <= row_idx[CW-1:0];
						state_q <= S_CUR;
					end else begin
						state_q <= S_GAP;
					end
				end
				S_CUR: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (shift) begin
						pos_q <= pos_dn;
						if (!more) begin
							state_q <= S_PUT;
						end
					end else begin
						i_q     <= i_q + CW'(1);
						state_q <= S_ROW;
					end
				end
				S_PUT: begin
					i_q     <= i_q + CW'(1);
					state_q <= S_ROW;
				end
				S_ERD: begin
					if (out_free) begin
						state_q <= S_EWAIT;
					end
				end
				S_EWAIT: begin
					if (is_final) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_LOAD;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_ERD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// current element picked up from the row read
	always_ff @(posedge clk) begin
		if (state_q == S_CUR) begin
			cur_q <= $signed(ram_rdata);
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_ITEMS))
		else $error("element count beyond capacity");

	a_hole_above_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (pos_q >= gap_q))
		else $error("compare with hole below the gap");

	a_gap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROW || state_q == S_CUR || state_q == S_CMP || state_q == S_PUT)
		|-> (gap_q != '0))
		else $error("sort pass with zero gap");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EWAIT) |-> (k_q < count_q))
		else $error("emit index beyond stored count");

endmodule

// ===== src/shell_sort_descending.sv =====
// Descending Shell sort. While loading, items (signed value, is_last) are written one per
// cycle into an element RAM of MAX_ITEMS entries; items beyond capacity are discarded and
// every result of that set then carries dropped. On the item marked last the set is sorted
// in place (gap from the count, then gap/3+1 per pass down to a pass with gap 1) and the
// values come out largest first, final_flag on the last. Each insertion reads its row
// element, shifts each smaller element below it up by the gap and writes it into the
// hole; each pass also has its gap update and the row check that ends it, and one more
// gap check precedes the output. Each result is read from the RAM, then loaded into the
// output register once that register is empty or being taken; this pacing is set by the
// single RAM read port with its registered read data. The last result waits in an output
// register while the next set loads. Depends on ssd_pkg, ssd_stream_if and ssd_seq.
`timescale 1ns / 1ps

module shell_sort_descending #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	ssd_in_if.sink     items,
	ssd_out_if.source  results
);

	ssd_pkg::ssd_emit_t            emit;
	logic signed [DATA_WIDTH-1:0]  emit_value;
	logic                          out_free;

	logic                          out_valid_q;
	logic signed [DATA_WIDTH-1:0]  out_value_q;
	logic                          out_final_q;
	logic                          out_dropped_q;

	ssd_seq #(
		.MAX_ITEMS  (MAX_ITEMS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.items      (items),
		.out_free   (out_free),
		.emit       (emit),
		.emit_value (emit_value)
	);

	// output register is free once empty or being taken
	assign out_free = !out_valid_q || results.ready;

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_value_q   <= emit_value;
			out_final_q   <= emit.final_flag;
			out_dropped_q <= emit.dropped;
		end
	end

	assign results.valid        = out_valid_q;
	assign results.sorted_value = out_value_q;
	assign results.final_flag   = out_final_q;
	assign results.dropped      = out_dropped_q;

	// checks
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> !out_valid_q)
		else $error("result loaded over a pending item");

endmodule
